// File: rtl/pqswm_pkg.sv
package pqswm_pkg;

   localparam logic [2:0] MODE_QPSK  = 3'd2;
   localparam logic [2:0] MODE_8PSK  = 3'd3;
   localparam logic [2:0] MODE_16QAM = 3'd4;

   localparam logic [1:0] CSR_BITS_PER_SYMBOL    = 2'd0;
   localparam logic [1:0] CSR_SAMPLES_PER_SYMBOL = 2'd1;
   localparam logic [1:0] CSR_PHASE_STEP         = 2'd2;
   localparam logic [1:0] CSR_AMPLITUDE          = 2'd3;

   localparam int RADIUS_W = 15;
   localparam int COS_W    = 15;
   localparam int AMP_W    = 16;
   localparam int AMPR_W   = 31;
   localparam int PROD_W   = 46;
   localparam int MAG_W    = 18;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = 2;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

   typedef logic [RADIUS_W-1:0] radius_type;
   typedef logic [15:0] theta16_type;

   localparam radius_type RADIUS_PSK = 15'd23170;

   function automatic radius_type qam_radius(input logic [1:0] pt);
      radius_type r;
      case (pt)
         2'd0: r = 15'd5793;
         2'd1: r = 15'd12953;
         2'd2: r = 15'd12953;
         2'd3: r = 15'd17378;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

   function automatic theta16_type qam_theta(input logic [1:0] pt);
      theta16_type t;
      case (pt)
         2'd0: t = 16'd8192;
         2'd1: t = 16'd3356;
         2'd2: t = 16'd13028;
         2'd3: t = 16'd8192;
         default: t = 16'd0;
      endcase
      return t;
   endfunction

   function automatic radius_type radius_of(input logic [2:0] mode, input logic [3:0] sym);
      radius_type r;
      case (mode)
         MODE_QPSK:  r = RADIUS_PSK;
         MODE_8PSK:  r = RADIUS_PSK;
         MODE_16QAM: r = qam_radius(sym[1:0]);
         default:    r = 15'd0;
      endcase
      return r;
   endfunction

   function automatic theta16_type theta16_of(input logic [2:0] mode, input logic [3:0] sym);
      theta16_type t;
      case (mode)
         MODE_QPSK:  t = 16'd24576 + {sym[1:0], 14'd0};
         MODE_8PSK:  t = 16'd8192 + {sym[2:0], 13'd0};
         MODE_16QAM: t = qam_theta(sym[1:0]) + {sym[3:2], 14'd0};
         default:    t = 16'd0;
      endcase
      return t;
   endfunction

   // (q * m) >> s gives q / d exactly for any 32-bit q, d = 132, 90, 56, 30, 12, 2
   function automatic logic [32:0] horner_recip(input logic [2:0] k);
      logic [32:0] m;
      case (k)
         3'd0: m = 33'd8329633544;
         3'd1: m = 33'd6108397933;
         3'd2: m = 33'd4908534053;
         3'd3: m = 33'd4581298450;
         3'd4: m = 33'd5726623062;
         3'd5: m = 33'd4294967296;
         default: m = 33'd0;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] horner_shift(input logic [2:0] k);
      logic [5:0] s;
      case (k)
         3'd0: s = 6'd40;
         3'd1: s = 6'd39;
         3'd2: s = 6'd38;
         3'd3: s = 6'd37;
         3'd4: s = 6'd36;
         3'd5: s = 6'd33;
         default: s = 6'd0;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/psk_qam_symbol_waveform_modulator_unit.sv
// QPSK / 8PSK / 16QAM passband modulator.
// Input channel (req_): push a 4-bit symbol while req_full is low; one item per
// symbol. Result channel (rsp_): while rsp_empty is low, rsp_sample and
// rsp_last_sample show the oldest carrier sample; pop takes it. Each symbol
// yields samples_per_symbol items (0 acts as 1, capped at MAX_SAMPLES), the
// last one flagged.
// Control port (csr_): write bits_per_symbol, samples_per_symbol, phase_step
// or amplitude by index, only while no symbol is in flight.
// Throughput: one sample per clock while the output queue has room, set by
// the single cosine table read port. A symbol passes the staging register,
// symbol queue, generator, table read and multiply stages to the output queue.
// Reset: the quarter-wave cosine table (2**(PHASE_BITS-2)+1 entries) is built
// by an iterative Horner unit, one entry at a time; req_full stays high
// meanwhile, control writes are taken.
// Stall: a popped-late result holds in a four-entry output queue; the sample
// generator pauses when it fills, and a two-entry symbol queue plus one
// staging register absorb pushes before req_full rises.
module psk_qam_symbol_waveform_modulator_unit #(
   parameter int MAX_SAMPLES = 64,
   parameter int PHASE_BITS  = 12,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [3:0]                    req_symbol,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last_sample,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DEPTH = (2 ** (PHASE_BITS - 2)) + 1;

   logic [2:0]  bps_ff, bps_in;
   logic [6:0]  sps_ff, sps_in;
   logic [11:0] step_ff, step_in;
   logic [15:0] amp_ff, amp_in;

   logic                          init_done;
   logic                          init_we;
   logic [PHASE_BITS-2:0]         init_addr;
   logic [pqswm_pkg::COS_W-1:0]   init_data;
   logic [PHASE_BITS-2:0]         rd_addr;
   logic [pqswm_pkg::COS_W-1:0]   rd_data;

   logic                          front_full;
   logic                          q_valid;
   logic                          q_pop;
   logic [pqswm_pkg::AMPR_W-1:0]  q_ampr;
   logic [PHASE_BITS-1:0]         q_theta;
   logic [CNT_W-1:0]              q_count;

   always_comb begin
      bps_in  = bps_ff;
      sps_in  = sps_ff;
      step_in = step_ff;
      amp_in  = amp_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pqswm_pkg::CSR_BITS_PER_SYMBOL:    bps_in  = csr_data[2:0];
            pqswm_pkg::CSR_SAMPLES_PER_SYMBOL: sps_in  = csr_data[6:0];
            pqswm_pkg::CSR_PHASE_STEP:         step_in = csr_data[11:0];
            pqswm_pkg::CSR_AMPLITUDE:          amp_in  = csr_data;
            default: begin
               bps_in = bps_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff  <= 3'd2;
         sps_ff  <= 7'd16;
         step_ff <= 12'd256;
         amp_ff  <= 16'd256;
      end else begin
         bps_ff  <= bps_in;
         sps_ff  <= sps_in;
         step_ff <= step_in;
         amp_ff  <= amp_in;
      end
   end

   pqswm_cos_init #(
      .PHASE_BITS(PHASE_BITS)
   ) u_cos_init (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (init_we),
      .wr_addr(init_addr),
      .wr_data(init_data),
      .done   (init_done)
   );

   pqswm_ram #(
      .WIDTH(pqswm_pkg::COS_W),
      .DEPTH(DEPTH)
   ) u_cos_ram (
      .clock  (clock),
      .wr_en  (init_we),
      .wr_addr(init_addr),
      .wr_data(init_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   pqswm_front #(
      .PHASE_BITS (PHASE_BITS),
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (req_push && init_done),
      .full              (front_full),
      .symbol            (req_symbol),
      .bits_per_symbol   (bps_ff),
      .samples_per_symbol(sps_ff),
      .amplitude         (amp_ff),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_ampr            (q_ampr),
      .q_theta           (q_theta),
      .q_count           (q_count)
   );

   pqswm_back #(
      .PHASE_BITS (PHASE_BITS),
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_ampr    (q_ampr),
      .q_theta   (q_theta),
      .q_count   (q_count),
      .phase_step(PHASE_BITS'(step_ff)),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_sample(rsp_sample),
      .out_last  (rsp_last_sample)
   );

   assign req_full = !init_done || front_full;

`ifndef SYNTHESIS
   a_hold_during_init: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> req_full)
      else $error("symbol accepted before cosine table is built");
`endif

endmodule

// File: rtl/pqswm_ram.sv
module pqswm_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pqswm_cos_init.sv
module pqswm_cos_init #(
   parameter int PHASE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          wr_en,
   output logic [PHASE_BITS-2:0]         wr_addr,
   output logic [pqswm_pkg::COS_W-1:0]   wr_data,
   output logic                          done
);

   localparam int AW = PHASE_BITS - 1;
   localparam int XW = AW + 31;
   localparam logic [AW-1:0] QUARTER = AW'(1) << (PHASE_BITS - 2);

   localparam logic [2:0] ST_X    = 3'd0;
   localparam logic [2:0] ST_X2   = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SUB  = 3'd4;
   localparam logic [2:0] ST_WR   = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] r_ff, r_in;
   logic [30:0]   x_ff, x_in;
   logic [31:0]   x2_ff, x2_in;
   logic [30:0]   f_ff, f_in;
   logic [2:0]    k_ff, k_in;
   logic [31:0]   q_ff, q_in;

   logic [XW-1:0] xprod;
   logic [61:0]   sq;
   logic [62:0]   hp;
   logic [64:0]   dprod;
   logic [31:0]   quot;
   logic [30:0]   f_nx;
   logic [30:0]   rnd;
   logic [15:0]   v;

   always_comb begin
      xprod = XW'(r_ff) * XW'(pqswm_pkg::HALF_PI_Q30);
      sq    = 62'(x_ff) * 62'(x_ff);
      hp    = 63'(x2_ff) * 63'(f_ff);
      dprod = 65'(q_ff) * 65'(pqswm_pkg::horner_recip(k_ff));
      quot  = 32'(dprod >> pqswm_pkg::horner_shift(k_ff));
      f_nx  = (q_ff >= 32'(pqswm_pkg::Q30_ONE)) ? 31'd0 : pqswm_pkg::Q30_ONE - q_ff[30:0];
      rnd   = f_ff + 31'h4000;
      v     = rnd[30:15];

      state_in = state_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      q_in     = q_ff;

      case (state_ff)
         ST_X: begin
            x_in     = xprod[PHASE_BITS-2 +: 31];
            state_in = ST_X2;
         end
         ST_X2: begin
            x2_in    = sq[30 +: 32];
            f_in     = pqswm_pkg::Q30_ONE;
            k_in     = 3'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            q_in     = hp[30 +: 32];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = quot;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            f_in     = f_nx;
            k_in     = k_ff + 3'd1;
            state_in = (k_ff == 3'd5) ? ST_WR : ST_MUL;
         end
         ST_WR: begin
            r_in     = r_ff + AW'(1);
            state_in = (r_ff == QUARTER) ? ST_DONE : ST_X;
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_X;
         r_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         k_ff     <= k_in;
      end
      x_ff   <= x_in;
      x2_ff  <= x2_in;
      f_ff   <= f_in;
      q_ff   <= q_in;
   end

   assign wr_en   = state_ff == ST_WR;
   assign wr_addr = r_ff;
   assign wr_data = (v > 16'd32767) ? 15'h7FFF : v[14:0];
   assign done    = state_ff == ST_DONE;

endmodule

// File: rtl/pqswm_front.sv
module pqswm_front #(
   parameter int PHASE_BITS  = 12,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [3:0]                            symbol,
   input  logic [2:0]                            bits_per_symbol,
   input  logic [6:0]                            samples_per_symbol,
   input  logic [pqswm_pkg::AMP_W-1:0]           amplitude,
   output logic                                  q_valid,
   input  logic                                  q_pop,
   output logic [pqswm_pkg::AMPR_W-1:0]          q_ampr,
   output logic [PHASE_BITS-1:0]                 q_theta,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]      q_count
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
   localparam int SH    = 16 - PHASE_BITS;
   localparam logic [16:0] HALF = 17'((1 << SH) >> 1);
   localparam logic [CW-1:0] MAX_X = CW'(MAX_SAMPLES);

   pqswm_pkg::radius_type  radius;
   pqswm_pkg::theta16_type theta16;
   logic [16:0]            tsum;
   logic [PHASE_BITS-1:0]  theta;
   logic [CW-1:0]          sps_x;
   logic [CNT_W-1:0]       count;

   logic                          fv_ff, fv_in;
   pqswm_pkg::radius_type         fr_ff;
   logic [PHASE_BITS-1:0]         ft_ff;
   logic [CNT_W-1:0]              fc_ff;

   logic [pqswm_pkg::AMPR_W-1:0]  qa_ff [2];
   logic [PHASE_BITS-1:0]         qt_ff [2];
   logic [CNT_W-1:0]              qc_ff [2];
   logic [1:0]                    qcnt_ff, qcnt_in;
   logic                          qwr_ff, qwr_in;
   logic                          qrd_ff, qrd_in;
   logic [pqswm_pkg::AMPR_W-1:0]  qa_in;

   logic move;
   logic take;
   logic pop;

   always_comb begin
      radius  = pqswm_pkg::radius_of(bits_per_symbol, symbol);
      theta16 = pqswm_pkg::theta16_of(bits_per_symbol, symbol);
      tsum    = 17'(theta16) + HALF;
      theta   = tsum[SH +: PHASE_BITS];
      sps_x   = CW'(samples_per_symbol);
      if (sps_x == '0) begin
         count = CNT_W'(1);
      end else if (sps_x > MAX_X) begin
         count = CNT_W'(MAX_SAMPLES);
      end else begin
         count = sps_x[CNT_W-1:0];
      end

      move  = fv_ff && (qcnt_ff != 2'd2);
      full  = fv_ff && !move;
      take  = push && !full;
      pop   = q_pop && (qcnt_ff != 2'd0);
      qa_in = pqswm_pkg::AMPR_W'(amplitude) * pqswm_pkg::AMPR_W'(fr_ff);

      fv_in   = take ? 1'b1 : (move ? 1'b0 : fv_ff);
      qcnt_in = qcnt_ff + {1'b0, move} - {1'b0, pop};
      qwr_in  = move ? !qwr_ff : qwr_ff;
      qrd_in  = pop ? !qrd_ff : qrd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff   <= 1'b0;
         qcnt_ff <= 2'd0;
         qwr_ff  <= 1'b0;
         qrd_ff  <= 1'b0;
      end else begin
         fv_ff   <= fv_in;
         qcnt_ff <= qcnt_in;
         qwr_ff  <= qwr_in;
         qrd_ff  <= qrd_in;
      end
      if (take) begin
         fr_ff <= radius;
         ft_ff <= theta;
         fc_ff <= count;
      end
      if (move) begin
         qa_ff[qwr_ff] <= qa_in;
         qt_ff[qwr_ff] <= ft_ff;
         qc_ff[qwr_ff] <= fc_ff;
      end
   end

   assign q_valid = qcnt_ff != 2'd0;
   assign q_ampr  = qa_ff[qrd_ff];
   assign q_theta = qt_ff[qrd_ff];
   assign q_count = qc_ff[qrd_ff];

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 2'd2)
      else $error("symbol queue over capacity");
`endif

endmodule

// File: rtl/pqswm_back.sv
module pqswm_back #(
   parameter int PHASE_BITS  = 12,
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   output logic                                  q_pop,
   input  logic [pqswm_pkg::AMPR_W-1:0]          q_ampr,
   input  logic [PHASE_BITS-1:0]                 q_theta,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]      q_count,
   input  logic [PHASE_BITS-1:0]                 phase_step,
   output logic [PHASE_BITS-2:0]                 rd_addr,
   input  logic [pqswm_pkg::COS_W-1:0]           rd_data,
   output logic                                  out_empty,
   input  logic                                  out_pop,
   output logic signed [SAMPLE_BITS-1:0]         out_sample,
   output logic                                  out_last
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int AW    = PHASE_BITS - 1;
   localparam int MW    = pqswm_pkg::MAG_W;
   localparam int CW    = ((SAMPLE_BITS > MW) ? SAMPLE_BITS : MW) + 1;
   localparam int PW    = pqswm_pkg::PROD_W;
   localparam int QAW   = pqswm_pkg::OQ_AW;
   localparam logic [AW-1:0] QUARTER = AW'(1) << (PHASE_BITS - 2);
   localparam logic [CW-1:0] LIM     = CW'(1) << (SAMPLE_BITS - 1);
   localparam logic [QAW:0]  OQ_FULL = (QAW+1)'(pqswm_pkg::OQ_DEPTH);

   logic                          act_ff, act_in;
   logic [pqswm_pkg::AMPR_W-1:0]  ampr_ff;
   logic [PHASE_BITS-1:0]         theta_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;

   logic                          v1_ff, neg1_ff, last1_ff;
   logic [pqswm_pkg::AMPR_W-1:0]  ampr1_ff;
   logic                          v2_ff, neg2_ff, last2_ff;
   logic [PW-1:0]                 prod2_ff;

   logic [SAMPLE_BITS-1:0]        os_ff [pqswm_pkg::OQ_DEPTH];
   logic                          ol_ff [pqswm_pkg::OQ_DEPTH];
   logic [QAW-1:0]                wp_ff, wp_in;
   logic [QAW-1:0]                rp_ff, rp_in;
   logic [QAW:0]                  oc_ff, oc_in;

   logic [PHASE_BITS-1:0] p;
   logic [1:0]            quad;
   logic [AW-1:0]         r;
   logic                  neg;
   logic [QAW:0]          pending;
   logic                  space;
   logic                  issue;
   logic                  issue_last;
   logic                  load;
   logic                  pop;
   logic [PW:0]           rsum;
   logic [CW-1:0]         mag;
   logic [CW-1:0]         clip;
   logic [CW-1:0]         sval;
   logic [SAMPLE_BITS-1:0] sample;

   always_comb begin
      p    = phase_ff + theta_ff;
      quad = p[PHASE_BITS-1 -: 2];
      r    = {1'b0, p[PHASE_BITS-3:0]};
      neg  = quad inside {2'd1, 2'd2};
      rd_addr = quad[0] ? (QUARTER - r) : r;

      pending    = oc_ff + {{QAW{1'b0}}, v1_ff} + {{QAW{1'b0}}, v2_ff};
      space      = pending < OQ_FULL;
      issue      = act_ff && space;
      issue_last = issue && ((idx_ff + CNT_W'(1)) == cnt_ff);
      load       = q_valid && (!act_ff || issue_last);
      q_pop      = load;

      act_in   = load ? 1'b1 : (issue_last ? 1'b0 : act_ff);
      idx_in   = load ? '0 : (issue ? idx_ff + CNT_W'(1) : idx_ff);
      phase_in = load ? '0 : (issue ? phase_ff + phase_step : phase_ff);

      rsum = {1'b0, prod2_ff} + ((PW+1)'(1) << 28);
      mag  = CW'(rsum[PW -: MW]);
      if (neg2_ff) begin
         clip = (mag > LIM) ? LIM : mag;
         sval = '0 - clip;
      end else begin
         clip = (mag > (LIM - CW'(1))) ? (LIM - CW'(1)) : mag;
         sval = clip;
      end
      sample = sval[SAMPLE_BITS-1:0];

      pop   = out_pop && (oc_ff != '0);
      wp_in = v2_ff ? wp_ff + QAW'(1) : wp_ff;
      rp_in = pop ? rp_ff + QAW'(1) : rp_ff;
      oc_in = oc_ff + {{QAW{1'b0}}, v2_ff} - {{QAW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         idx_ff <= '0;
         phase_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         oc_ff  <= '0;
      end else begin
         act_ff   <= act_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         oc_ff    <= oc_in;
      end
      if (load) begin
         ampr_ff  <= q_ampr;
         theta_ff <= q_theta;
         cnt_ff   <= q_count;
      end
      neg1_ff  <= neg;
      last1_ff <= issue_last;
      ampr1_ff <= ampr_ff;
      neg2_ff  <= neg1_ff;
      last2_ff <= last1_ff;
      prod2_ff <= PW'(ampr1_ff) * PW'(rd_data);
      if (v2_ff) begin
         os_ff[wp_ff] <= sample;
         ol_ff[wp_ff] <= last2_ff;
      end
   end

   assign out_empty  = oc_ff == '0;
   assign out_sample = os_ff[rp_ff];
   assign out_last   = ol_ff[rp_ff];

`ifndef SYNTHESIS
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oc_ff <= OQ_FULL)
      else $error("output queue over capacity");
   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (oc_ff < OQ_FULL))
      else $error("sample written into a full output queue");
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("multiply stage valid without a table read");
`endif

endmodule
